### hw/rtl/mep_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel unit.
package mep_pkg;

  localparam int FRAC_BITS = 28;
  localparam int Z_W       = 33;                   // z and c components, signed Q5.28
  localparam int SQ_W      = 2 * Z_W - FRAC_BITS;  // squared terms after the shift
  localparam int FOUR_Q    = 1 << 30;              // 4.0 in Q4.28
  localparam int ADDR_W    = 26;
  localparam int STEP_W    = 31;
  localparam int LIMIT_W   = 16;
  localparam int STRIDE_W  = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic MODE_TABLE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  localparam logic signed [31:0]      RST_LEFT_REAL  = -32'sd536870912;
  localparam logic signed [31:0]      RST_TOP_IMAG   = 32'sd402653184;
  localparam logic [STEP_W-1:0]       RST_STEP_SIZE  = 31'd786432;
  localparam logic [LIMIT_W-1:0]      RST_ITER_LIMIT = 16'd255;
  localparam logic [STRIDE_W-1:0]     RST_ROW_STRIDE = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_REAL  = 3'd0,
    CFG_TOP_IMAG   = 3'd1,
    CFG_STEP_SIZE  = 3'd2,
    CFG_ITER_LIMIT = 3'd3,
    CFG_ROW_STRIDE = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_MUL,
    ST_SETUP_C,
    ST_RUN,
    ST_LOOKUP,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic signed [31:0]   left_real;
    logic signed [31:0]   top_imag;
    logic [STEP_W-1:0]    step_size;
    logic [LIMIT_W-1:0]   iter_limit;
    logic [STRIDE_W-1:0]  row_stride;
  } mep_cfg_t;

  typedef struct packed {
    logic load_coord;  // capture pixel coordinates
    logic table_wr;    // write one color table entry
    logic setup_mul;   // coordinate products
    logic setup_c;     // c, address, clear iteration state
    logic iterate;     // one z = z*z + c step
    logic lookup;      // color table read
    logic out_load;    // move result into output register
  } mep_cmd_t;

  typedef struct packed {
    logic iter_done;   // escaped or limit reached
  } mep_status_t;

endpackage

### hw/rtl/mep_ctrl.sv
// Sequencing state machine for the Mandelbrot escape-time pixel unit.
module mep_ctrl
  import mep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        mode_i,
  input  logic        out_free_i,
  input  mep_status_t status_i,
  output logic        in_stall_o,
  output mep_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (mode_i == MODE_RENDER) begin
            cmd_o.load_coord = 1'b1;
            state_d          = ST_SETUP_MUL;
          end else begin
            cmd_o.table_wr = 1'b1;
          end
        end
      end
      ST_SETUP_MUL: begin
        cmd_o.setup_mul = 1'b1;
        state_d         = ST_SETUP_C;
      end
      ST_SETUP_C: begin
        cmd_o.setup_c = 1'b1;
        state_d       = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.iter_done) begin
          state_d = ST_LOOKUP;
        end else begin
          cmd_o.iterate = 1'b1;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/mep_datapath.sv
// Coordinate mapping, escape iteration, address and color table datapath.
module mep_datapath
  import mep_pkg::*;
#(
  parameter int COLOR_ENTRIES = 256,
  parameter int COORD_WIDTH   = 12,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                   clk_i,
  input  mep_cmd_t               cmd_i,
  input  mep_cfg_t               cfg_i,
  input  logic [11:0]            pixel_x_i,
  input  logic [11:0]            pixel_y_i,
  input  logic [7:0]             color_index_i,
  input  logic [31:0]            color_value_i,
  output mep_status_t            status_o,
  output logic [ADDR_W-1:0]      pixel_address_o,
  output logic [31:0]            pixel_rgba_o,
  output logic [COUNT_WIDTH-1:0] escape_count_o
);

  localparam int IDX_W  = $clog2(COLOR_ENTRIES);
  localparam int PROD_W = COORD_WIDTH + STEP_W;
  localparam int CPT_W  = PROD_W + 2;
  localparam int LIN_W  = COORD_WIDTH + STRIDE_W;
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic signed [CPT_W-1:0] C_HI = CPT_W'(FOUR_Q);
  localparam logic signed [CPT_W-1:0] C_LO = -C_HI;
  localparam logic signed [SQ_W:0]    ESC_TH = (SQ_W + 1)'(FOUR_Q);

  logic [COORD_WIDTH-1:0] px_q, py_q;
  logic [PROD_W-1:0]      xs_q, ys_q;
  logic [LIN_W-1:0]       ylin_q;
  logic signed [Z_W-1:0]  cr_q, ci_q;
  logic [ADDR_W-1:0]      addr_q;
  logic signed [SQ_W-1:0] zr2_q, zi2_q, cross_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [IDX_W-1:0]       idx_q;
  logic [31:0]            rgba_q;
  logic [31:0]            mem_q [COLOR_ENTRIES];

  logic signed [CPT_W-1:0]  cx_sum, cy_sum;
  logic signed [Z_W-1:0]    cr_d, ci_d;
  logic [31:0]              lin;
  logic signed [Z_W-1:0]    nzr, nzi;
  logic signed [2*Z_W-1:0]  p_rr, p_ii, p_ri;
  logic signed [SQ_W:0]     mag;
  logic [COUNT_WIDTH-1:0]   lim;
  logic                     wr_ok;
  logic [IDX_W-1:0]         wr_addr;

  // c real = x * step + left_real, c imag = y * step - top_imag, each clamped to +-4.0
  always_comb begin
    cx_sum = $signed({2'b00, xs_q}) + CPT_W'(cfg_i.left_real);
    cy_sum = $signed({2'b00, ys_q}) - CPT_W'(cfg_i.top_imag);
    if (cx_sum > C_HI) begin
      cr_d = Z_W'(C_HI);
    end else if (cx_sum < C_LO) begin
      cr_d = Z_W'(C_LO);
    end else begin
      cr_d = Z_W'(cx_sum);
    end
    if (cy_sum > C_HI) begin
      ci_d = Z_W'(C_HI);
    end else if (cy_sum < C_LO) begin
      ci_d = Z_W'(C_LO);
    end else begin
      ci_d = Z_W'(cy_sum);
    end
  end

  assign lin = 32'(ylin_q) + 32'(px_q);

  // one iteration: new z from the registered squares, then its products
  always_comb begin
    nzr  = Z_W'(zr2_q) - Z_W'(zi2_q) + cr_q;
    nzi  = (Z_W'(cross_q) <<< 1) + ci_q;
    p_rr = (2*Z_W)'(nzr) * (2*Z_W)'(nzr);
    p_ii = (2*Z_W)'(nzi) * (2*Z_W)'(nzi);
    p_ri = (2*Z_W)'(nzr) * (2*Z_W)'(nzi);
  end

  assign mag = (SQ_W + 1)'(zr2_q) + (SQ_W + 1)'(zi2_q);
  assign lim = (33'(cfg_i.iter_limit) > CNT_MAX) ? '1 : COUNT_WIDTH'(cfg_i.iter_limit);
  assign status_o.iter_done = (count_q == lim) || (mag >= ESC_TH);

  assign wr_ok   = 32'(color_index_i) < COLOR_ENTRIES;
  assign wr_addr = IDX_W'(color_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coord) begin
      px_q <= COORD_WIDTH'(pixel_x_i);
      py_q <= COORD_WIDTH'(pixel_y_i);
    end
    if (cmd_i.setup_mul) begin
      xs_q   <= PROD_W'(px_q) * PROD_W'(cfg_i.step_size);
      ys_q   <= PROD_W'(py_q) * PROD_W'(cfg_i.step_size);
      ylin_q <= LIN_W'(py_q) * LIN_W'(cfg_i.row_stride);
    end
    if (cmd_i.setup_c) begin
      cr_q    <= cr_d;
      ci_q    <= ci_d;
      addr_q  <= {lin[ADDR_W-3:0], 2'b00};
      zr2_q   <= '0;
      zi2_q   <= '0;
      cross_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end
    if (cmd_i.iterate) begin
      zr2_q   <= $signed(p_rr[2*Z_W-1:FRAC_BITS]);
      zi2_q   <= $signed(p_ii[2*Z_W-1:FRAC_BITS]);
      cross_q <= $signed(p_ri[2*Z_W-1:FRAC_BITS]);
      count_q <= count_q + 1'b1;
      if (idx_q == IDX_W'(COLOR_ENTRIES - 1)) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // color table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.table_wr && wr_ok) begin
      mem_q[wr_addr] <= color_value_i;
    end
    if (cmd_i.lookup) begin
      rgba_q <= mem_q[idx_q];
    end
  end

  assign pixel_address_o = addr_q;
  assign pixel_rgba_o    = rgba_q;
  assign escape_count_o  = count_q;

endmodule

### hw/rtl/mandelbrot_escape_pixel_unit.sv
// Top level of the Mandelbrot escape-time pixel unit.
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per item. mode_i = 0
//   writes color_value_i into color table entry color_index_i in the cycle it is
//   accepted; no result follows. mode_i = 1 renders pixel (pixel_x_i, pixel_y_i).
//   Output channel (out_valid_o / out_stall_i): one transaction per render item,
//   carrying the byte address, the RGBA word and the escape count.
//   Config port (cfg_we_i / cfg_index_i / cfg_data_i): write only while idle.
// Timing:
//   An accepted render item goes through the coordinate products, the c setup,
//   the escape loop, the color table lookup and then into the output register.
//   The escape loop does one z = z*z + c step per cycle until escape or the
//   iteration limit. Table writes go at one per cycle while no pixel is busy.
//   Input stall stays high while a pixel is being worked on.
// Reset: config registers return to their defaults, the controller goes idle and
//   the output register empties. The color table is not cleared: an entry must
//   be written before a pixel can select it.
// Stall: a finished result waits in the output register; the next item can be
//   accepted meanwhile, and its result waits in the datapath until the slot frees.
module mandelbrot_escape_pixel_unit
  import mep_pkg::*;
#(
  parameter int COLOR_ENTRIES = 256,
  parameter int COORD_WIDTH   = 12,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [11:0]          pixel_x_i,
  input  logic [11:0]          pixel_y_i,
  input  logic [7:0]           color_index_i,
  input  logic [31:0]          color_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    pixel_address_o,
  output logic [31:0]          pixel_rgba_o,
  output logic [15:0]          escape_count_o
);

  mep_cfg_t    cfg_q;
  mep_cmd_t    cmd;
  mep_status_t status;

  logic [ADDR_W-1:0]      dp_addr;
  logic [31:0]            dp_rgba;
  logic [COUNT_WIDTH-1:0] dp_count;

  logic                   out_valid_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic [31:0]            out_rgba_q;
  logic [15:0]            out_count_q;
  logic                   out_free;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_real  <= RST_LEFT_REAL;
      cfg_q.top_imag   <= RST_TOP_IMAG;
      cfg_q.step_size  <= RST_STEP_SIZE;
      cfg_q.iter_limit <= RST_ITER_LIMIT;
      cfg_q.row_stride <= RST_ROW_STRIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LEFT_REAL:  cfg_q.left_real  <= $signed(cfg_data_i);
        CFG_TOP_IMAG:   cfg_q.top_imag   <= $signed(cfg_data_i);
        CFG_STEP_SIZE:  cfg_q.step_size  <= cfg_data_i[STEP_W-1:0];
        CFG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_ROW_STRIDE: cfg_q.row_stride <= cfg_data_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  mep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  mep_datapath #(
    .COLOR_ENTRIES (COLOR_ENTRIES),
    .COORD_WIDTH   (COORD_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .cfg_i           (cfg_q),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .color_index_i   (color_index_i),
    .color_value_i   (color_value_i),
    .status_o        (status),
    .pixel_address_o (dp_addr),
    .pixel_rgba_o    (dp_rgba),
    .escape_count_o  (dp_count)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_addr_q  <= dp_addr;
      out_rgba_q  <= dp_rgba;
      out_count_q <= 16'(dp_count);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_rgba_o    = out_rgba_q;
  assign escape_count_o  = out_count_q;

endmodule
